@@ sv/physical_page_free_list_allocator_assert.svh @@
// assertion macros for the page allocator
`ifndef PHYSICAL_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PPFL_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, disabled during reset
`define PPFL_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PPFL_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define PPFL_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

@@ sv/ppfl_pkg.sv @@
package ppfl_pkg;

    // sizing of the page store
    localparam int MAX_PAGES = 65536;
    localparam int MEM_DEPTH = (MAX_PAGES < 65536) ? MAX_PAGES : 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PAGE_W    = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // largest usable page count
    localparam logic [CFG_W-1:0] ACTIVE_MAX = CFG_W'(MEM_DEPTH);

    // commands
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_INIT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_END = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_PAGE_COUNT   = 17'd65536;
    localparam logic [CFG_W-1:0] RST_BASE_PAGES   = 17'd160;
    localparam logic [CFG_W-1:0] RST_RESERVED_END = 17'd1024;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PAGE_W-1:0] page_index;
    } t_cmd_in;

    typedef struct packed {
        logic [PAGE_W-1:0] granted_page;
        logic [1:0]        status;
    } t_result;

    // write side of the page store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              free;
        logic [PAGE_W-1:0] link;
    } t_mem_wr;

endpackage

@@ sv/ppfl_store.sv @@
module ppfl_store (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [ppfl_pkg::ADDR_W-1:0]   i_rd_addr,
    input  ppfl_pkg::t_mem_wr             i_wr,
    output logic                          o_rd_free,
    output logic [ppfl_pkg::PAGE_W-1:0]   o_rd_link
);

    // per-page entry: free bit above the link to the next page
    logic [ppfl_pkg::PAGE_W:0] r_mem [ppfl_pkg::MEM_DEPTH];
    logic [ppfl_pkg::PAGE_W:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= {i_wr.free, i_wr.link};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_free = r_rd_data[ppfl_pkg::PAGE_W];
    assign o_rd_link = r_rd_data[ppfl_pkg::PAGE_W-1:0];

endmodule

@@ sv/physical_page_free_list_allocator.sv @@
// channel   | direction | transfer when
// ----------+-----------+------------------------------------------
// command   | in        | start high and busy low at a clock edge
// result    | out       | o_result_valid high for one cycle
// config    | in        | i_cfg_we high at a clock edge
//
// alloc and free: the accept cycle issues the store read, the next does the write-back
// and head update; busy drops and the result shows after it.
// init walks every store entry once, top down.
// after reset a clearing pass over every store entry holds busy high.
// results cannot be held off; a new command may be taken while one shows.
module physical_page_free_list_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ppfl_pkg::t_cmd_in                i_cmd,
    output logic                             o_result_valid,
    output ppfl_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [ppfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppfl_pkg::CFG_W-1:0]       i_cfg_wdata
);

`include "physical_page_free_list_allocator_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    localparam logic [ppfl_pkg::ADDR_W-1:0] WALK_TOP =
        ppfl_pkg::ADDR_W'(ppfl_pkg::MEM_DEPTH - 1);

    logic [1:0]                      r_state, n_state;
    logic [ppfl_pkg::CFG_W-1:0]      r_page_count, r_base_pages, r_resv_end;
    logic [ppfl_pkg::PAGE_W-1:0]     r_head, n_head;
    logic [ppfl_pkg::ADDR_W-1:0]     r_walk, n_walk;
    logic                            r_walk_init, n_walk_init;
    logic                            r_res_valid, n_res_valid;
    ppfl_pkg::t_result               r_res, n_res;
    logic [1:0]                      r_cmd;
    logic [ppfl_pkg::PAGE_W-1:0]     r_pg;

    logic                            accept;
    logic [ppfl_pkg::ADDR_W-1:0]     rd_addr;
    logic                            rd_free;
    logic [ppfl_pkg::PAGE_W-1:0]     rd_link;
    ppfl_pkg::t_mem_wr               mem_wr;
    logic [ppfl_pkg::CFG_W-1:0]      active;
    logic [ppfl_pkg::CFG_W-1:0]      walk_page;
    logic                            walk_listed;
    logic                            free_ok;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // read the head entry for alloc, the named page otherwise
    assign rd_addr = (i_cmd.cmd == ppfl_pkg::CMD_ALLOC) ?
                     r_head[ppfl_pkg::ADDR_W-1:0] :
                     i_cmd.page_index[ppfl_pkg::ADDR_W-1:0];

    ppfl_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr      (mem_wr),
        .o_rd_free (rd_free),
        .o_rd_link (rd_link)
    );

    // usable page count
    assign active = (r_page_count > ppfl_pkg::ACTIVE_MAX) ?
                    ppfl_pkg::ACTIVE_MAX : r_page_count;

    // page under the init walk joins the list unless page 0, beyond range or reserved
    assign walk_page   = ppfl_pkg::CFG_W'(r_walk);
    assign walk_listed = r_walk_init && (walk_page != '0) && (walk_page < active) &&
                         !((walk_page >= r_base_pages) && (walk_page < r_resv_end));

    // free accepted for a managed page not already on the list
    assign free_ok = (r_pg != '0) && ({1'b0, r_pg} < active) && !rd_free;

    // command sequencing
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_walk      = r_walk;
        n_walk_init = r_walk_init;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_wr      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.cmd == ppfl_pkg::CMD_INIT) begin
                        n_state     = S_WALK;
                        n_walk      = WALK_TOP;
                        n_walk_init = 1'b1;
                        n_head      = '0;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state            = S_IDLE;
                n_res_valid        = 1'b1;
                n_res.granted_page = '0;
                n_res.status       = ppfl_pkg::ST_REJECT;
                case (r_cmd)
                    ppfl_pkg::CMD_ALLOC: begin
                        if (r_head == '0) begin
                            n_res.status = ppfl_pkg::ST_EMPTY;
                        end else begin
                            n_res.granted_page = r_head;
                            n_res.status       = ppfl_pkg::ST_OK;
                            n_head             = rd_link;
                            mem_wr.we          = 1'b1;
                            mem_wr.addr        = r_head[ppfl_pkg::ADDR_W-1:0];
                            mem_wr.free        = 1'b0;
                            mem_wr.link        = rd_link;
                        end
                    end
                    ppfl_pkg::CMD_FREE: begin
                        if (free_ok) begin
                            n_res.status = ppfl_pkg::ST_OK;
                            n_head       = r_pg;
                            mem_wr.we    = 1'b1;
                            mem_wr.addr  = r_pg[ppfl_pkg::ADDR_W-1:0];
                            mem_wr.free  = 1'b1;
                            mem_wr.link  = r_head;
                        end
                    end
                    default: begin
                        n_res.status = ppfl_pkg::ST_REJECT;
                    end
                endcase
            end
            S_WALK: begin
                // rewrite one entry a cycle, pushing listed pages
                mem_wr.we   = 1'b1;
                mem_wr.addr = r_walk;
                mem_wr.free = walk_listed;
                mem_wr.link = walk_listed ? r_head : '0;
                if (walk_listed) begin
                    n_head = ppfl_pkg::PAGE_W'(r_walk);
                end
                if (r_walk == '0) begin
                    n_state = S_IDLE;
                    if (r_walk_init) begin
                        n_res_valid        = 1'b1;
                        n_res.granted_page = '0;
                        n_res.status       = ppfl_pkg::ST_INIT;
                    end
                end else begin
                    n_walk = r_walk - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WALK;
            r_walk      <= WALK_TOP;
            r_walk_init <= 1'b0;
            r_head      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_walk_init <= n_walk_init;
            r_head      <= n_head;
            r_res_valid <= n_res_valid;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_cmd <= i_cmd.cmd;
            r_pg  <= i_cmd.page_index;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= ppfl_pkg::RST_PAGE_COUNT;
            r_base_pages <= ppfl_pkg::RST_BASE_PAGES;
            r_resv_end   <= ppfl_pkg::RST_RESERVED_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppfl_pkg::REG_PAGE_COUNT:   r_page_count <= i_cfg_wdata;
                ppfl_pkg::REG_BASE_PAGES:   r_base_pages <= i_cfg_wdata;
                ppfl_pkg::REG_RESERVED_END: r_resv_end   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    // a result only follows an executed command or a finished init walk
    `PPFL_ASSERT_IMPLY(a_res_source, i_clk, i_rst_n, o_result_valid,
        $past(r_state == S_EXEC) || $past(r_state == S_WALK && r_walk_init))
    // an accepted command always keeps the block busy for the next cycle
    `PPFL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a successful alloc never grants page 0
    `PPFL_ASSERT_IMPLY(a_grant_nonzero, i_clk, i_rst_n,
        o_result_valid && r_cmd == ppfl_pkg::CMD_ALLOC && o_result.status == ppfl_pkg::ST_OK,
        o_result.granted_page != '0)

endmodule

@@ verif/free_list_checker.sv @@
`timescale 1ns / 1ps

// watches the command, result and register channels of the page allocator,
// keeps its own copy of the free list and compares every result transfer
module free_list_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  ppfl_pkg::t_cmd_in              i_cmd,
    input  logic                           i_result_valid,
    input  ppfl_pkg::t_result              i_result,
    input  logic                           i_cfg_we,
    input  logic [ppfl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppfl_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                             o_errors,
    output int                             o_pending
);
    import ppfl_pkg::*;

    // shadow copy of the page store and list head
    bit [PAGE_W-1:0]  next_link [MEM_DEPTH];
    bit               free_map  [MEM_DEPTH];
    bit [PAGE_W-1:0]  head;
    bit               head_ok;
    logic [CFG_W-1:0] pages_reg;
    logic [CFG_W-1:0] base_reg;
    logic [CFG_W-1:0] resv_end_reg;

    // replies still owed by the block, oldest first
    t_result reply_queue [$];
    int      mismatch_count = 0;

    // page count clipped to what the store holds
    function automatic int unsigned usable_pages();
        int unsigned n;
        n = pages_reg;
        if (n > MEM_DEPTH) begin
            n = MEM_DEPTH;
        end
        return n;
    endfunction

    // put a page on top of the list
    function automatic void push_frame(int unsigned p);
        next_link[p] = head_ok ? head : '0;
        free_map[p]  = 1'b1;
        head         = PAGE_W'(p);
        head_ok      = 1'b1;
    endfunction

    // relink every usable page above 0 outside the reserved window, top down
    function automatic void rebuild_list();
        int unsigned n;
        int unsigned p;
        n = usable_pages();
        foreach (free_map[i]) begin
            free_map[i] = 1'b0;
        end
        head    = '0;
        head_ok = 1'b0;
        for (int unsigned i = n; i > 1; i--) begin
            p = i - 1;
            if (!(p >= base_reg && p < resv_end_reg)) begin
                push_frame(p);
            end
        end
    endfunction

    // reply to one command, updating the shadow list
    function automatic t_result free_list_reply(t_cmd_in c);
        t_result         r;
        bit [PAGE_W-1:0] taken;
        r.granted_page = '0;
        case (c.cmd)
            CMD_INIT: begin
                rebuild_list();
                r.status = ST_INIT;
            end
            CMD_ALLOC: begin
                if (!head_ok) begin
                    r.status = ST_EMPTY;
                end else begin
                    taken           = head;
                    free_map[taken] = 1'b0;
                    r.granted_page  = taken;
                    head            = next_link[taken];
                    head_ok         = (head != '0);
                    r.status        = ST_OK;
                end
            end
            CMD_FREE: begin
                if (c.page_index == '0 || c.page_index >= usable_pages()
                        || free_map[c.page_index]) begin
                    r.status = ST_REJECT;
                end else begin
                    push_frame(c.page_index);
                    r.status = ST_OK;
                end
            end
            default: begin
                r.status = ST_REJECT;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            pages_reg    = RST_PAGE_COUNT;
            base_reg     = RST_BASE_PAGES;
            resv_end_reg = RST_RESERVED_END;
            foreach (free_map[i]) begin
                free_map[i] = 1'b0;
            end
            head    = '0;
            head_ok = 1'b0;
            reply_queue.delete();
        end else begin
            // result transfer against the oldest owed reply
            if (i_result_valid) begin
                if (reply_queue.size() == 0) begin
                    $display("%0t: unexpected result, granted_page %0d status %0d",
                             $time, i_result.granted_page, i_result.status);
                    mismatch_count++;
                end else begin
                    want = reply_queue.pop_front();
                    if (want.granted_page !== i_result.granted_page) begin
                        $display("%0t: granted_page expected %0d actual %0d",
                                 $time, want.granted_page, i_result.granted_page);
                        mismatch_count++;
                    end
                    if (want.status !== i_result.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_result.status);
                        mismatch_count++;
                    end
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PAGE_COUNT:   pages_reg    = i_cfg_wdata;
                    REG_BASE_PAGES:   base_reg     = i_cfg_wdata;
                    REG_RESERVED_END: resv_end_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // command transfer
            if (i_start && !i_busy) begin
                reply_queue.push_back(free_list_reply(i_cmd));
            end
        end
        o_pending <= reply_queue.size();
        o_errors  <= mismatch_count;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ppfl_pkg::*;

    localparam logic [1:0]  CMD_SPARE       = 2'd3;
    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam int          PHASES          = 9;
    localparam int          ITEMS_PER_PHASE = 136;
    localparam int          RANDOM_PHASE    = 7;
    localparam int          PRESSURE_PHASE  = 1;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    t_cmd_in              i_cmd          = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [CFG_W-1:0]     i_cfg_wdata    = '0;
    int                   fail_count;
    int                   open_replies;
    int unsigned          cycle_count    = 0;

    // pages handed out, reused as well-formed frees
    logic [PAGE_W-1:0] granted_pool [$];

    // register settings per phase: page count, base pages, reserved end
    int unsigned phase_pages [PHASES] = '{16, 40, 0, 1, 65536, 131071, 300, 0, 65536};
    int unsigned phase_base  [PHASES] = '{4, 30, 0, 0, 0, 1, 100, 0, 160};
    int unsigned phase_resv  [PHASES] = '{8, 10, 0, 65536, 65536, 2, 200, 0, 1024};

    always #5 i_clk = ~i_clk;

    physical_page_free_list_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    free_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_errors       (fail_count),
        .o_pending      (open_replies)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // collect granted pages mid-cycle, clear of the driving edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_result_valid && o_result.status == ST_OK
                && o_result.granted_page != '0) begin
            granted_pool.push_back(o_result.granted_page);
        end
    end

    // hold one command until the block takes it; start stays high afterwards
    task automatic issue(input logic [1:0] op, input logic [PAGE_W-1:0] pg);
        start <= 1'b1;
        i_cmd <= '{cmd: op, page_index: pg};
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // sender gap
    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending until every reply is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy !== 1'b0 || open_replies != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned       roll;
        int unsigned       usable;
        int unsigned       pages_val;
        int unsigned       base_val;
        int unsigned       resv_val;
        int                count;
        int                burst_left;
        int                pick;
        bit                steady;
        bit                pressed;
        logic [1:0]        op;
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] last_freed;

        // reset, then wait out the clearing pass
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // directed: list empty before any init
        issue(CMD_ALLOC, 16'hFFFF);
        issue(CMD_FREE, 16'h0000);
        issue(CMD_FREE, 16'd5);
        issue(CMD_FREE, 16'd5);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_SPARE, 16'hFFFF);
        issue(CMD_FREE, 16'hFFFF);
        issue(CMD_ALLOC, 16'h5A5A);
        issue(CMD_FREE, 16'd500);
        // directed: build with reset settings, then pops and pushes
        issue(CMD_INIT, 16'hA5A5);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, 16'd1);
        issue(CMD_FREE, 16'd1);
        issue(CMD_FREE, 16'd3);
        issue(CMD_FREE, 16'd500);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_FREE, 16'h8000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_ALLOC, 16'h0000);
        issue(CMD_SPARE, 16'h0000);
        settle();

        // random phases, each under its own register setting
        pressed    = 1'b0;
        last_freed = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            pages_val = phase_pages[ph];
            base_val  = phase_base[ph];
            resv_val  = phase_resv[ph];
            if (ph == RANDOM_PHASE) begin
                pages_val = $urandom_range(2, 64);
                base_val  = $urandom_range(0, 70);
                resv_val  = $urandom_range(0, 70);
            end
            usable = (pages_val > MEM_DEPTH) ? MEM_DEPTH : pages_val;
            steady = (ph % 3 == 2);
            granted_pool.delete();

            write_reg(REG_PAGE_COUNT, CFG_W'(pages_val));
            write_reg(REG_BASE_PAGES, CFG_W'(base_val));
            write_reg(REG_RESERVED_END, CFG_W'(resv_val));
            i_cfg_we <= 1'b0;
            issue(CMD_INIT, PAGE_W'($urandom));

            count      = 0;
            burst_left = $urandom_range(1, 20);
            while (count < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                op   = CMD_FREE;
                pg   = PAGE_W'($urandom);
                if (roll < 45) begin
                    op = CMD_ALLOC;
                end else if (roll < 75) begin
                    if (granted_pool.size() > 0) begin
                        pick = $urandom_range(0, granted_pool.size() - 1);
                        pg   = granted_pool[pick];
                        granted_pool.delete(pick);
                    end
                end else if (roll < 85) begin
                    if (usable > 1) begin
                        pg = PAGE_W'($urandom_range(1, usable - 1));
                    end
                end else if (roll < 89) begin
                    pg = '0;
                end else if (roll < 93) begin
                    if (usable < MEM_DEPTH) begin
                        pg = PAGE_W'($urandom_range(usable, MEM_DEPTH - 1));
                    end
                end else if (roll < 97) begin
                    // double free of the last page sent back
                    pg = last_freed;
                end else begin
                    op = CMD_SPARE;
                end

                issue(op, pg);
                if (op == CMD_FREE) begin
                    last_freed = pg;
                end
                if (op != CMD_SPARE) begin
                    count++;
                end

                // let everything drain once in the middle of the pressure phase
                if (ph == PRESSURE_PHASE && !pressed && count >= ITEMS_PER_PHASE / 2) begin
                    pressed = 1'b1;
                    settle();
                end

                // bursts with random gaps between them, except in steady phases
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    if (!steady) begin
                        pause($urandom_range(1, 6));
                    end
                end
            end
            settle();
        end

        // trailing cycles for any stray result
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && open_replies == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ physical_page_free_list_allocator.f @@
+incdir+sv
sv/ppfl_pkg.sv
sv/ppfl_store.sv
sv/physical_page_free_list_allocator.sv
verif/free_list_checker.sv
verif/tb.sv
